// ===== src/upd_pkg.sv =====
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and constants for the URI percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Decoded length saturates at the smaller of the string limit and 16 bits.
  localparam longint unsigned MaxStringLen = 64'd65535;
  localparam logic [15:0]     CountLimit   =
      (MaxStringLen > 64'd65535) ? 16'hFFFF : MaxStringLen[15:0];

  localparam logic [7:0] ChPercent  = 8'h25;
  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChNine     = 8'h39;
  localparam logic [7:0] ChLowA     = 8'h61;
  localparam logic [7:0] ChLowF     = 8'h66;
  localparam logic [7:0] CaseBit    = 8'h20;
  localparam logic [7:0] ChDel      = 8'h7F;

  localparam int unsigned ModeUriBit      = 0;
  localparam int unsigned ModeRedirectBit = 1;
  localparam logic [1:0]  ModeReset       = 2'd1;

  // Results of one input byte: up to three data bytes, then an optional
  // closing result carrying the length.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n_bytes;
    logic            eos;
    logic [15:0]     length;
  } upd_bundle_t;

  // {not_hex, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [7:0] low;
    low = ch | CaseBit;
    if (ch >= ChZero && ch <= ChNine) begin
      hex_value = {1'b0, ch[3:0]};
    end else if (low >= ChLowA && low <= ChLowF) begin
      hex_value = {1'b0, low[3:0] + 4'd9};
    end else begin
      hex_value = 5'h10;
    end
  endfunction

endpackage

// ===== src/upd_decode.sv =====
// ----------------------------------------------------------------------------
// upd_decode
// Escape state machine: turns one input byte into a bundle of results.
// ----------------------------------------------------------------------------
module upd_decode import upd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_string_i,
  input  logic [1:0]  mode_i,
  output logic        load_o,
  output upd_bundle_t bundle_o
);

  localparam logic [1:0] PhPlain  = 2'd0;
  localparam logic [1:0] PhQuoted = 2'd1;
  localparam logic [1:0] PhSecond = 2'd2;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  high_nibble_q, high_nibble_d;
  logic [7:0]  first_hex_q, first_hex_d;
  logic        stopped_q, stopped_d;
  logic [15:0] count_q, count_d;

  logic [4:0]  hv;
  logic [7:0]  dec;
  logic        is_digit, in_range;
  logic [17:0] count_sum;
  logic [15:0] count_new;

  assign hv       = hex_value(in_byte_i);
  assign dec      = {high_nibble_q, hv[3:0]};
  assign is_digit = (in_byte_i >= ChZero) && (in_byte_i <= ChNine);
  assign in_range = (dec > ChPercent) && (dec < ChDel);

  always_comb begin
    phase_d       = phase_q;
    high_nibble_d = high_nibble_q;
    first_hex_d   = first_hex_q;
    stopped_d     = stopped_q;
    bundle_o      = '0;

    if (!stopped_q) begin
      unique case (phase_q)
        PhPlain: begin
          if (in_byte_i == ChQuestion && mode_i != 2'd0) begin
            bundle_o.bytes[0] = in_byte_i;
            bundle_o.n_bytes  = 2'd1;
            stopped_d         = 1'b1;
          end else if (in_byte_i == ChPercent) begin
            phase_d = PhQuoted;
          end else begin
            bundle_o.bytes[0] = in_byte_i;
            bundle_o.n_bytes  = 2'd1;
          end
        end
        PhQuoted: begin
          if (!hv[4]) begin
            high_nibble_d = hv[3:0];
            first_hex_d   = in_byte_i;
            phase_d       = PhSecond;
          end else begin
            // lone '%' is dropped, the byte goes out as is
            phase_d           = PhPlain;
            bundle_o.bytes[0] = in_byte_i;
            bundle_o.n_bytes  = 2'd1;
          end
        end
        PhSecond: begin
          phase_d = PhPlain;
          if (!hv[4]) begin
            bundle_o.bytes[0] = dec;
            bundle_o.n_bytes  = 2'd1;
            if (is_digit) begin
              if (mode_i[ModeRedirectBit] && !in_range) begin
                bundle_o.bytes   = {in_byte_i, first_hex_q, ChPercent};
                bundle_o.n_bytes = 2'd3;
              end
            end else if (mode_i[ModeUriBit]) begin
              stopped_d = (dec == ChQuestion);
            end else if (mode_i[ModeRedirectBit]) begin
              if (dec == ChQuestion) begin
                stopped_d = 1'b1;
              end else if (!in_range) begin
                bundle_o.bytes   = {in_byte_i, first_hex_q, ChPercent};
                bundle_o.n_bytes = 2'd3;
              end
            end
          end
        end
        default: begin
          phase_d = PhPlain;
        end
      endcase
    end

    // saturating length; count never exceeds the limit
    count_sum = {2'b00, count_q} + {16'd0, bundle_o.n_bytes};
    count_new = (count_sum >= {2'b00, CountLimit}) ? CountLimit : count_sum[15:0];
    count_d   = count_new;

    if (end_of_string_i) begin
      bundle_o.eos    = 1'b1;
      bundle_o.length = count_new;
      phase_d         = PhPlain;
      stopped_d       = 1'b0;
      count_d         = '0;
    end
  end

  assign load_o = accept_i && (bundle_o.eos || bundle_o.n_bytes != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhPlain;
      high_nibble_q <= '0;
      first_hex_q   <= '0;
      stopped_q     <= 1'b0;
      count_q       <= '0;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      high_nibble_q <= high_nibble_d;
      first_hex_q   <= first_hex_d;
      stopped_q     <= stopped_d;
      count_q       <= count_d;
    end
  end

endmodule

// ===== src/upd_outq.sv =====
// ----------------------------------------------------------------------------
// upd_outq
// Result register: holds one bundle, one result out a cycle while unstalled.
// ----------------------------------------------------------------------------
module upd_outq import upd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  upd_bundle_t bundle_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        last_of_run_o,
  output logic        string_done_o,
  output logic [15:0] decoded_length_o
);

  logic        valid_q;
  upd_bundle_t bundle_q;
  logic [1:0]  idx_q;
  logic        is_close, last, take;

  assign is_close = (idx_q == bundle_q.n_bytes);
  assign last     = bundle_q.eos ? is_close : (idx_q == bundle_q.n_bytes - 2'd1);
  assign take     = valid_q && !out_stall_i;
  assign free_o   = !valid_q || (take && last);

  assign out_valid_o      = valid_q;
  assign byte_valid_o     = !is_close;
  assign string_done_o    = is_close;
  assign last_of_run_o    = last;
  assign out_byte_o       = is_close ? 8'd0 : bundle_q.bytes[idx_q];
  assign decoded_length_o = is_close ? bundle_q.length : 16'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (free_o) begin
      valid_q <= load_i;
      idx_q   <= '0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

// ===== src/uri_percent_decoder_core.sv =====
// ----------------------------------------------------------------------------
// uri_percent_decoder_core
// URI percent decoder, one byte in per cycle unless stalled, with stop-at-'?'
// and redirect re-escaping modes and a closing length result per string.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | input     | in_valid_i/in_stall_o | in_byte_i, end_of_string_i
//  out     | output    | out_valid_o/out_stall_i | out_byte_o, byte_valid_o,
//          |           |                       | last_of_run_o, string_done_o,
//          |           |                       | decoded_length_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (mode)
//
//  Flow: an input byte is decoded in the cycle it is accepted; its results
//  appear from the next cycle. A byte giving k results (0 to 4) holds the
//  result register until its last result transfers, so throughput is one byte
//  per cycle for plain text while out_stall_i is low, and lower for bytes
//  with more than one result. The result register is the only buffer; a new
//  byte is taken in the cycle the last result of the previous one transfers.
//  Reset: asynchronous, active low; mode returns to URI mode, decoder state
//  to plain text with a zero count. Configuration is always ready.
//  Stalls: out_stall_i holds the result; in_stall_o waits for its last one.
// ----------------------------------------------------------------------------
module uri_percent_decoder_core import upd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_string_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        last_of_run_o,
  output logic        string_done_o,
  output logic [15:0] decoded_length_o
);

  logic [1:0]  mode_q;
  logic        free;
  logic        accept;
  logic        load;
  upd_bundle_t bundle;

  // mode register, written whenever a transfer occurs on cfg
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // a byte is taken while the result register is empty or as its last result transfers
  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  upd_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .end_of_string_i(end_of_string_i),
    .mode_i         (mode_q),
    .load_o         (load),
    .bundle_o       (bundle)
  );

  upd_outq u_outq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .bundle_i        (bundle),
    .free_o          (free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .last_of_run_o   (last_of_run_o),
    .string_done_o   (string_done_o),
    .decoded_length_o(decoded_length_o)
  );

endmodule

// ===== dv/tb_uri_percent_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_uri_percent_decoder_core
// Self-checking bench for the URI percent decoder core. A queue of raw bytes
// feeds a clocked driver; a clocked monitor compares every result transfer
// with the decoded bytes and closing lengths predicted for each accepted
// input byte. Directed strings hit the escape corner cases, then random
// strings run under every mode.
// ----------------------------------------------------------------------------
module tb_uri_percent_decoder_core import upd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Values written to the mode register
  localparam logic [1:0] ModePlain    = 2'd0;
  localparam logic [1:0] ModeUri      = 2'd1;
  localparam logic [1:0] ModeRedirect = 2'd2;
  localparam logic [1:0] ModeBoth     = 2'd3;

  // Receiver hold-offs: length in cycles, and how many of them
  localparam int HoldCycles = 150;
  localparam int HoldCount  = 2;

  typedef enum logic [1:0] {PhPlain, PhQuoted, PhSecond} esc_phase_e;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } raw_byte_t;

  typedef struct {
    logic [7:0]  data;
    logic        data_valid;
    logic        last;
    logic        done;
    logic [15:0] length;
  } decoded_t;

  // DUT ports; every input is known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i      = ModeReset;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i       = 8'h00;
  logic        end_of_string_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        last_of_run_o;
  logic        string_done_o;
  logic [15:0] decoded_length_o;

  uri_percent_decoder_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .end_of_string_i  (end_of_string_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .byte_valid_o     (byte_valid_o),
    .last_of_run_o    (last_of_run_o),
    .string_done_o    (string_done_o),
    .decoded_length_o (decoded_length_o)
  );

  always #4 clk_i = ~clk_i;

  // Bench state
  raw_byte_t  raw_q[$];      // bytes waiting for the driver
  decoded_t   decoded_q[$];  // results owed by the DUT, oldest first
  decoded_t   run_buf[$];    // results of the byte being decoded
  int         queued_total = 0;
  int         mismatches   = 0;
  int         xfer_count   = 0;  // accepted input transfers
  int         hold_left    = 0;
  int         holds_done   = 0;
  int         src_wait     = 0;
  int         src_run      = 0;
  bit         src_idle     = 1'b0;
  int         sink_wait    = 0;
  int         sink_run     = 0;
  bit         sink_idle    = 1'b0;

  // Predictor state, mirrors the decoder
  logic [1:0]  dec_mode    = ModeReset;
  esc_phase_e  dec_phase   = PhPlain;
  logic [3:0]  dec_nibble  = 4'h0;
  logic [7:0]  dec_first   = 8'h00;
  logic        dec_stopped = 1'b0;
  logic [15:0] dec_count   = 16'h0000;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Low five bits: bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [7:0] lc;
    lc = ch | 8'h20;
    if (ch >= ChZero && ch <= ChNine) return {1'b0, ch[3:0]};
    if (lc >= ChLowA && lc <= ChLowF) return {1'b0, lc[3:0] + 4'd9};
    return 5'h10;
  endfunction

  // Decoded values that redirect mode lets through unescaped
  function automatic logic stays_plain(input logic [7:0] d);
    return d > ChPercent && d < ChDel;
  endfunction

  function automatic void emit(input logic [7:0] b);
    run_buf.push_back('{data: b, data_valid: 1'b1, last: 1'b0, done: 1'b0,
                        length: 16'h0000});
    if (dec_count < CountLimit) dec_count++;
  endfunction

  function automatic void emit_escaped(input logic [7:0] second);
    emit(ChPercent);
    emit(dec_first);
    emit(second);
  endfunction

  // Works out the results of one accepted byte and queues them
  task automatic decode_byte(input logic [7:0] ch, input logic eos);
    logic [4:0] hv;
    logic [7:0] dec;
    run_buf.delete();
    if (!dec_stopped) begin
      case (dec_phase)
        PhPlain: begin
          if (ch == ChQuestion && dec_mode != ModePlain) begin
            emit(ch);
            dec_stopped = 1'b1;
          end else if (ch == ChPercent) begin
            dec_phase = PhQuoted;
          end else begin
            emit(ch);
          end
        end
        PhQuoted: begin
          hv = hex_digit(ch);
          if (!hv[4]) begin
            dec_nibble = hv[3:0];
            dec_first  = ch;
            dec_phase  = PhSecond;
          end else begin
            // lone '%' dropped, byte goes out as is
            dec_phase = PhPlain;
            emit(ch);
          end
        end
        default: begin
          dec_phase = PhPlain;
          hv = hex_digit(ch);
          // a bad second digit drops the whole escape
          if (!hv[4]) begin
            dec = {dec_nibble, hv[3:0]};
            if (ch >= ChZero && ch <= ChNine) begin
              // decimal second digit: redirect rule only, never a '?'
              if (dec_mode[ModeRedirectBit] && !stays_plain(dec)) emit_escaped(ch);
              else emit(dec);
            end else if (dec_mode[ModeUriBit]) begin
              emit(dec);
              if (dec == ChQuestion) dec_stopped = 1'b1;
            end else if (dec_mode[ModeRedirectBit]) begin
              if (dec == ChQuestion) begin
                emit(dec);
                dec_stopped = 1'b1;
              end else if (stays_plain(dec)) begin
                emit(dec);
              end else begin
                emit_escaped(ch);
              end
            end else begin
              emit(dec);
            end
          end
        end
      endcase
    end
    if (eos) begin
      run_buf.push_back('{data: 8'h00, data_valid: 1'b0, last: 1'b0, done: 1'b1,
                          length: dec_count});
      dec_phase   = PhPlain;
      dec_stopped = 1'b0;
      dec_count   = 16'h0000;
    end
    if (run_buf.size() != 0) run_buf[run_buf.size() - 1].last = 1'b1;
    foreach (run_buf[i]) decoded_q.push_back(run_buf[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Idle draws: stretches of items with random gaps between them, and stretches
  // with none at all
  // ---------------------------------------------------------------------------
  task automatic pick_wait(inout int run_left, inout bit idle_on, output int w);
    if (run_left == 0) begin
      run_left = $urandom_range(5, 30);
      idle_on  = ($urandom_range(0, 2) != 0);
    end
    run_left--;
    w = idle_on ? $urandom_range(0, 4) : 0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: prediction happens on the edge the transfer is taken. A stalled
  // byte is held; otherwise the next one is offered once the gap has run out.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic      taken;
    raw_byte_t item;
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      in_byte_i       <= 8'h00;
      end_of_string_i <= 1'b0;
      xfer_count      <= 0;
      src_wait = 0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        decode_byte(in_byte_i, end_of_string_i);
        xfer_count <= xfer_count + 1;
        pick_wait(src_run, src_idle, src_wait);
      end
      if (in_valid_i && !taken) begin
        // stalled: payload and valid stay put
      end else if (src_wait != 0) begin
        src_wait--;
        in_valid_i <= 1'b0;
      end else if (raw_q.size() != 0) begin
        item = raw_q.pop_front();
        in_byte_i       <= item.ch;
        end_of_string_i <= item.eos;
        in_valid_i      <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-offs, counted here. Triggered after 40 and 140 input
  // transfers, while the sender keeps offering, so the result register fills
  // and the input side stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < HoldCount && xfer_count >= 40 + 100 * holds_done) begin
      hold_left  <= HoldCycles;
      holds_done <= holds_done + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          $error("result transfer with nothing expected: byte %0h done %0b",
                 out_byte_o, string_done_o);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", 16'(want.data), 16'(out_byte_o));
          check_field("byte_valid", 16'(want.data_valid), 16'(byte_valid_o));
          check_field("last_of_run", 16'(want.last), 16'(last_of_run_o));
          check_field("string_done", 16'(want.done), 16'(string_done_o));
          check_field("decoded_length", want.length, decoded_length_o);
        end
        pick_wait(sink_run, sink_idle, sink_wait);
      end else if (out_valid_o && sink_wait != 0) begin
        sink_wait--;
      end
      out_stall_i <= (hold_left != 0) || (sink_wait != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_char(input logic [7:0] ch, input logic eos);
    raw_q.push_back('{ch: ch, eos: eos});
    queued_total++;
  endfunction

  function automatic void queue_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) push_char(s[i], close && i == s.len() - 1);
  endfunction

  function automatic logic [7:0] rand_hex();
    int n;
    n = $urandom_range(0, 15);
    if (n < 10) return ChZero + 8'(n);
    return (($urandom_range(0, 1) != 0) ? ChLowA : (ChLowA & ~CaseBit)) + 8'(n - 10);
  endfunction

  // One string of plain text, escapes, '?', raw bytes and broken escapes;
  // most end with end-of-string, some run on into the next
  task automatic queue_random_string();
    logic [7:0] text[$];
    logic [7:0] b;
    int         tokens;
    tokens = $urandom_range(1, 8);
    for (int t = 0; t < tokens; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          b = 8'($urandom_range(8'h20, 8'h7e));
          text.push_back((b == ChPercent) ? 8'h7e : b);
        end
        4, 5, 6: begin
          text.push_back(ChPercent);
          text.push_back(rand_hex());
          text.push_back(rand_hex());
        end
        7: text.push_back(ChQuestion);
        8: text.push_back(8'($urandom_range(0, 255)));
        default: begin
          text.push_back(ChPercent);
          if ($urandom_range(0, 1) != 0) text.push_back(rand_hex());
          if ($urandom_range(0, 3) != 0) text.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    foreach (text[i])
      push_char(text[i], i == text.size() - 1 && $urandom_range(0, 7) != 0);
  endtask

  task automatic queue_random(input int count);
    int stop_at;
    stop_at = queued_total + count;
    while (queued_total < stop_at) queue_random_string();
  endtask

  // Idle: nothing queued, nothing offered, nothing owed, then a further wait
  // for a byte that produced no result
  task automatic drain_idle();
    do @(negedge clk_i);
    while (raw_q.size() != 0 || in_valid_i || decoded_q.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] value);
    @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dec_mode = value;
  endtask

  initial begin
    logic [1:0] modes[5];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset mode (URI): decode, lone '%', bad second digit, byte extremes,
    // decoded '?' stopping the string, dangling '%' at end of string
    queue_text("%41%zq%4x", 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b1);
    queue_text("%3Fb", 1'b1);
    queue_text("%", 1'b1);
    drain_idle();

    // Both bits: letter second digit stops on '?', digit one re-escapes;
    // string left open on a half escape across the mode write
    write_mode(ModeBoth);
    queue_text("%3f", 1'b1);
    queue_text("%19%0", 1'b0);
    drain_idle();
    write_mode(ModeRedirect);
    queue_text("a", 1'b1);
    queue_text("%4", 1'b1);
    drain_idle();

    // Random strings under every mode, extremes first
    modes = '{ModePlain, ModeBoth, ModeRedirect, ModeUri, 2'($urandom_range(0, 3))};
    foreach (modes[i]) begin
      write_mode(modes[i]);
      queue_random(40);
      drain_idle();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
